### src/rti_pkg.sv
// Shared constants and types for the ray/triangle intersection pipeline.
`default_nettype none

package rti_pkg;

   localparam int COORD_BITS_DEF = 24;
   localparam int DIR_BITS       = 16;
   localparam int DIR_FRAC       = 14;
   localparam int CSR_IDX_BITS   = 3;

   // register indexes on the csr port
   localparam logic [CSR_IDX_BITS-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_DIR_X    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_DIR_Y    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_DIR_Z    = 3'd5;

   // direction z resets to +1.0 in Q1.14
   localparam logic signed [DIR_BITS-1:0] DIR_Z_RESET = 16'sd16384;

   // flags that ride along the divider stages
   typedef struct packed {
      logic valid;
      logic hit;
      logic sat;
   } tag_type;

endpackage

`default_nettype wire

### src/rti_div_stage.sv
// One restoring-division step: resolves a single quotient bit per stage.
`default_nettype none

module rti_div_stage #(
   parameter int RW    = 92,
   parameter int DNW   = 68,
   parameter int QB    = 24,
   parameter int SHIFT = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire rti_pkg::tag_type tag_in,
   input  wire logic [RW-1:0]    rem_in,
   input  wire logic [DNW-1:0]   den_in,
   input  wire logic [QB-1:0]    quo_in,
   output rti_pkg::tag_type      tag_out,
   output logic [RW-1:0]         rem_out,
   output logic [DNW-1:0]        den_out,
   output logic [QB-1:0]         quo_out
);

   rti_pkg::tag_type tag_ff;
   logic [RW-1:0]    rem_ff, rem_in_nx, den_sh;
   logic [DNW-1:0]   den_ff;
   logic [QB-1:0]    quo_ff, quo_in_nx;
   logic             ge;

   always_comb begin
      den_sh    = RW'(den_in) << SHIFT;
      ge        = rem_in >= den_sh;
      rem_in_nx = ge ? rem_in - den_sh : rem_in;
      quo_in_nx = quo_in;
      quo_in_nx[SHIFT] = ge;
   end

   // only the valid flag is reset; data just follows it
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else if (adv) begin
         tag_ff.valid <= tag_in.valid;
      end
      if (adv) begin
         tag_ff.hit <= tag_in.hit;
         tag_ff.sat <= tag_in.sat;
         rem_ff     <= rem_in_nx;
         den_ff     <= den_in;
         quo_ff     <= quo_in_nx;
      end
   end

   assign tag_out = tag_ff;
   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign quo_out = quo_ff;

endmodule

`default_nettype wire

### src/ray_triangle_intersect.sv
// Top level: pipelined Moller-Trumbore ray/triangle test against one configured ray.
//
// Usage:
//  - csr_*: set ray origin (fixed point, 8 fraction bits) and unit direction
//    (Q1.14) while the pipeline is empty. csr_we writes csr_wdata to register
//    csr_index; unknown indexes are ignored.
//  - req_*: one triangle (three corners) per item, accepted when req_valid is
//    high and req_stall low.
//  - rsp_*: one result per item, in order: rsp_hit and rsp_hit_distance
//    (0 on a miss, saturated at all ones on a far hit).
//  - Pipeline: 8 arithmetic stages (edges, cross products, split dot products,
//    sign fix, tests) then one restoring-division stage per distance bit.
//  - Throughput: one item per cycle, no bubbles while rsp_stall is low.
//  - rsp_stall freezes the whole pipeline; req_stall is raised only while a
//    result is held at the output. Nothing is dropped or repeated.
//  - Reset (synchronous) empties the pipeline and restores origin 0 and
//    direction (0, 0, +1).
`default_nettype none

module ray_triangle_intersect #(
   parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [rti_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  wire logic [COORD_BITS-1:0]                 csr_wdata,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [COORD_BITS-1:0]          req_vertex_a_x,
   input  wire logic signed [COORD_BITS-1:0]          req_vertex_a_y,
   input  wire logic signed [COORD_BITS-1:0]          req_vertex_a_z,
   input  wire logic signed [COORD_BITS-1:0]          req_vertex_b_x,
   input  wire logic signed [COORD_BITS-1:0]          req_vertex_b_y,
   input  wire logic signed [COORD_BITS-1:0]          req_vertex_b_z,
   input  wire logic signed [COORD_BITS-1:0]          req_vertex_c_x,
   input  wire logic signed [COORD_BITS-1:0]          req_vertex_c_y,
   input  wire logic signed [COORD_BITS-1:0]          req_vertex_c_z,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_hit,
   output logic [COORD_BITS-1:0]                      rsp_hit_distance
);

   localparam int CB   = COORD_BITS;
   localparam int DIRW = rti_pkg::DIR_BITS;
   localparam int EW   = CB + 1;          // edge / offset vectors
   localparam int PPW  = DIRW + EW;       // d x e2 product
   localparam int PW   = PPW + 1;         // p
   localparam int QPW  = 2 * EW;          // s x e1 product
   localparam int QW   = QPW + 1;         // q
   localparam int PL   = PW / 2;          // low split of p
   localparam int PHW  = PW - PL;
   localparam int QL   = QW / 2;          // low split of q
   localparam int QHW  = QW - QL;
   localparam int DLW  = EW + PL + 1;
   localparam int DHW  = EW + PHW;
   localparam int VLW  = DIRW + QL + 1;
   localparam int VHW  = DIRW + QHW;
   localparam int TLW  = EW + QL + 1;
   localparam int THW  = EW + QHW;
   localparam int DTW  = EW + PW;         // e1.p and s.p terms
   localparam int VTW  = DIRW + QW;       // d.q terms
   localparam int TTW  = EW + QW;         // e2.q terms
   localparam int WW   = EW + QW + 3;     // common width for D, U, V, T
   localparam int DNW  = WW - 1;          // magnitude of D
   localparam int RW   = DNW + CB;        // division remainder

   // ---------------- configuration ----------------
   logic signed [CB-1:0]   origin_ff [3];
   logic signed [DIRW-1:0] dir_ff    [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= '0;
         dir_ff[0]    <= '0;
         dir_ff[1]    <= '0;
         dir_ff[2]    <= rti_pkg::DIR_Z_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rti_pkg::REG_ORIGIN_X: origin_ff[0] <= csr_wdata;
            rti_pkg::REG_ORIGIN_Y: origin_ff[1] <= csr_wdata;
            rti_pkg::REG_ORIGIN_Z: origin_ff[2] <= csr_wdata;
            rti_pkg::REG_DIR_X:    dir_ff[0]    <= csr_wdata[DIRW-1:0];
            rti_pkg::REG_DIR_Y:    dir_ff[1]    <= csr_wdata[DIRW-1:0];
            rti_pkg::REG_DIR_Z:    dir_ff[2]    <= csr_wdata[DIRW-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   // Whole pipeline moves together; only a held result stops it.
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   logic [6:0] vld_ff;   // valid bits of stages 1..7

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[5:0], req_valid};
      end
   end

   // ---------------- stage 1: edges ----------------
   logic signed [CB-1:0] va [3], vb [3], vc [3];
   assign va[0] = req_vertex_a_x;
   assign va[1] = req_vertex_a_y;
   assign va[2] = req_vertex_a_z;
   assign vb[0] = req_vertex_b_x;
   assign vb[1] = req_vertex_b_y;
   assign vb[2] = req_vertex_b_z;
   assign vc[0] = req_vertex_c_x;
   assign vc[1] = req_vertex_c_y;
   assign vc[2] = req_vertex_c_z;

   logic signed [EW-1:0] e1_in [3], e2_in [3], s_in [3];
   logic signed [EW-1:0] e1_1_ff [3], e2_1_ff [3], s_1_ff [3];
   logic signed [EW-1:0] e1_2_ff [3], e2_2_ff [3], s_2_ff [3];
   logic signed [EW-1:0] e1_3_ff [3], e2_3_ff [3], s_3_ff [3];

   // stage 2: cross-product terms
   logic signed [PPW-1:0] pa_in [3], pb_in [3], pa_ff [3], pb_ff [3];
   logic signed [QPW-1:0] qa_in [3], qb_in [3], qa_ff [3], qb_ff [3];
   // stage 3: p = d x e2, q = s x e1
   logic signed [PW-1:0]  p_in [3], p_ff [3];
   logic signed [QW-1:0]  q_in [3], q_ff [3];
   // stage 4: split dot-product partials
   logic signed [DLW-1:0] dl_in [3], dl_ff [3], ul_in [3], ul_ff [3];
   logic signed [DHW-1:0] dh_in [3], dh_ff [3], uh_in [3], uh_ff [3];
   logic signed [VLW-1:0] vl_in [3], vl_ff [3];
   logic signed [VHW-1:0] vh_in [3], vh_ff [3];
   logic signed [TLW-1:0] tl_in [3], tl_ff [3];
   logic signed [THW-1:0] th_in [3], th_ff [3];
   // stage 5: full terms
   logic signed [DTW-1:0] dt_in [3], dt_ff [3], ut_in [3], ut_ff [3];
   logic signed [VTW-1:0] vt_in [3], vt_ff [3];
   logic signed [TTW-1:0] tt_in [3], tt_ff [3];

   for (genvar i = 0; i < 3; i++) begin : g_lane
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;

      assign e1_in[i] = EW'(vb[i]) - EW'(va[i]);
      assign e2_in[i] = EW'(vc[i]) - EW'(va[i]);
      assign s_in[i]  = EW'(origin_ff[i]) - EW'(va[i]);

      assign pa_in[i] = PPW'(dir_ff[J]) * PPW'(e2_1_ff[K]);
      assign pb_in[i] = PPW'(dir_ff[K]) * PPW'(e2_1_ff[J]);
      assign qa_in[i] = QPW'(s_1_ff[J]) * QPW'(e1_1_ff[K]);
      assign qb_in[i] = QPW'(s_1_ff[K]) * QPW'(e1_1_ff[J]);

      assign p_in[i] = PW'(pa_ff[i]) - PW'(pb_ff[i]);
      assign q_in[i] = QW'(qa_ff[i]) - QW'(qb_ff[i]);

      // low halves are unsigned, high halves carry the sign
      assign dl_in[i] = DLW'(e1_3_ff[i]) * DLW'($signed({1'b0, p_ff[i][PL-1:0]}));
      assign dh_in[i] = DHW'(e1_3_ff[i]) * DHW'($signed(p_ff[i][PW-1:PL]));
      assign ul_in[i] = DLW'(s_3_ff[i]) * DLW'($signed({1'b0, p_ff[i][PL-1:0]}));
      assign uh_in[i] = DHW'(s_3_ff[i]) * DHW'($signed(p_ff[i][PW-1:PL]));
      assign vl_in[i] = VLW'(dir_ff[i]) * VLW'($signed({1'b0, q_ff[i][QL-1:0]}));
      assign vh_in[i] = VHW'(dir_ff[i]) * VHW'($signed(q_ff[i][QW-1:QL]));
      assign tl_in[i] = TLW'(e2_3_ff[i]) * TLW'($signed({1'b0, q_ff[i][QL-1:0]}));
      assign th_in[i] = THW'(e2_3_ff[i]) * THW'($signed(q_ff[i][QW-1:QL]));

      assign dt_in[i] = (DTW'(dh_ff[i]) <<< PL) + DTW'(dl_ff[i]);
      assign ut_in[i] = (DTW'(uh_ff[i]) <<< PL) + DTW'(ul_ff[i]);
      assign vt_in[i] = (VTW'(vh_ff[i]) <<< QL) + VTW'(vl_ff[i]);
      assign tt_in[i] = (TTW'(th_ff[i]) <<< QL) + TTW'(tl_ff[i]);
   end

   // stage 6: D, U, V, T
   logic signed [WW-1:0] dsum_in, usum_in, vsum_in, tsum_in;
   logic signed [WW-1:0] dsum_ff, usum_ff, vsum_ff, tsum_ff;
   assign dsum_in = WW'(dt_ff[0]) + WW'(dt_ff[1]) + WW'(dt_ff[2]);
   assign usum_in = WW'(ut_ff[0]) + WW'(ut_ff[1]) + WW'(ut_ff[2]);
   assign vsum_in = WW'(vt_ff[0]) + WW'(vt_ff[1]) + WW'(vt_ff[2]);
   assign tsum_in = WW'(tt_ff[0]) + WW'(tt_ff[1]) + WW'(tt_ff[2]);

   // stage 7: fold the sign of D into all four
   logic signed [WW-1:0] dn_in, un_in, vn_in, tn_in;
   logic signed [WW-1:0] dn_ff, un_ff, vn_ff, tn_ff;
   logic                 zero_in, zero_ff, dneg;
   assign dneg    = dsum_ff[WW-1];
   assign dn_in   = dneg ? -dsum_ff : dsum_ff;
   assign un_in   = dneg ? -usum_ff : usum_ff;
   assign vn_in   = dneg ? -vsum_ff : vsum_ff;
   assign tn_in   = dneg ? -tsum_ff : tsum_ff;
   assign zero_in = dsum_ff == '0;

   // stage 8: inside/ahead tests, saturation check, dividend setup
   logic signed [WW-1:0] uv_sum;
   logic                 miss;
   logic [RW-1:0]        num_in, dsh;
   rti_pkg::tag_type     tag8_in;
   assign uv_sum = un_ff + vn_ff;
   assign miss   = zero_ff || un_ff[WW-1] || (un_ff > dn_ff) || vn_ff[WW-1] ||
                   (uv_sum > dn_ff) || tn_ff[WW-1] || (tn_ff == '0);
   assign num_in = RW'({tn_ff[WW-2:0], {rti_pkg::DIR_FRAC{1'b0}}});
   assign dsh    = {dn_ff[WW-2:0], {CB{1'b0}}};
   assign tag8_in.valid = vld_ff[6];
   assign tag8_in.hit   = !miss;
   assign tag8_in.sat   = num_in >= dsh;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            e1_1_ff[i] <= e1_in[i];
            e2_1_ff[i] <= e2_in[i];
            s_1_ff[i]  <= s_in[i];
            e1_2_ff[i] <= e1_1_ff[i];
            e2_2_ff[i] <= e2_1_ff[i];
            s_2_ff[i]  <= s_1_ff[i];
            e1_3_ff[i] <= e1_2_ff[i];
            e2_3_ff[i] <= e2_2_ff[i];
            s_3_ff[i]  <= s_2_ff[i];
            pa_ff[i]   <= pa_in[i];
            pb_ff[i]   <= pb_in[i];
            qa_ff[i]   <= qa_in[i];
            qb_ff[i]   <= qb_in[i];
            p_ff[i]    <= p_in[i];
            q_ff[i]    <= q_in[i];
            dl_ff[i]   <= dl_in[i];
            dh_ff[i]   <= dh_in[i];
            ul_ff[i]   <= ul_in[i];
            uh_ff[i]   <= uh_in[i];
            vl_ff[i]   <= vl_in[i];
            vh_ff[i]   <= vh_in[i];
            tl_ff[i]   <= tl_in[i];
            th_ff[i]   <= th_in[i];
            dt_ff[i]   <= dt_in[i];
            ut_ff[i]   <= ut_in[i];
            vt_ff[i]   <= vt_in[i];
            tt_ff[i]   <= tt_in[i];
         end
         dsum_ff <= dsum_in;
         usum_ff <= usum_in;
         vsum_ff <= vsum_in;
         tsum_ff <= tsum_in;
         dn_ff   <= dn_in;
         un_ff   <= un_in;
         vn_ff   <= vn_in;
         tn_ff   <= tn_in;
         zero_ff <= zero_in;
      end
   end

   // stage 8 registers
   rti_pkg::tag_type tag8_ff;
   logic [RW-1:0]    num_ff;
   logic [DNW-1:0]   den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag8_ff.valid <= 1'b0;
      end else if (adv) begin
         tag8_ff.valid <= tag8_in.valid;
      end
      if (adv) begin
         tag8_ff.hit <= tag8_in.hit;
         tag8_ff.sat <= tag8_in.sat;
         num_ff      <= num_in;
         den_ff      <= dn_ff[WW-2:0];
      end
   end

   // ---------------- divider: one quotient bit per stage, MSB first ----------------
   rti_pkg::tag_type tag_w [CB+1];
   logic [RW-1:0]    rem_w [CB+1];
   logic [DNW-1:0]   den_w [CB+1];
   logic [CB-1:0]    quo_w [CB+1];

   assign tag_w[0] = tag8_ff;
   assign rem_w[0] = num_ff;
   assign den_w[0] = den_ff;
   assign quo_w[0] = '0;

   for (genvar g = 0; g < CB; g++) begin : g_div
      rti_div_stage #(
         .RW    (RW),
         .DNW   (DNW),
         .QB    (CB),
         .SHIFT (CB - 1 - g)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .tag_in  (tag_w[g]),
         .rem_in  (rem_w[g]),
         .den_in  (den_w[g]),
         .quo_in  (quo_w[g]),
         .tag_out (tag_w[g+1]),
         .rem_out (rem_w[g+1]),
         .den_out (den_w[g+1]),
         .quo_out (quo_w[g+1])
      );
   end

   // ---------------- result ----------------
   assign rsp_valid        = tag_w[CB].valid;
   assign rsp_hit          = tag_w[CB].hit;
   assign rsp_hit_distance = !tag_w[CB].hit ? '0 :
                             tag_w[CB].sat  ? '1 : quo_w[CB];

   // ---------------- checks ----------------
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid right after reset");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[0])
      else $error("accepted item did not enter stage 1");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> vld_ff == $past(vld_ff))
      else $error("pipeline moved while stalled");

   a_hit_nonzero_det: assert property (@(posedge clock) disable iff (reset)
      tag8_ff.valid && tag8_ff.hit |-> den_ff != '0)
      else $error("hit with zero determinant");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit && !tag_w[CB].sat |-> rem_w[CB] < RW'(den_w[CB]))
      else $error("division remainder not below divisor");

endmodule

`default_nettype wire
